/* rtl/fca_pkg.sv */
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the chain allocator: payload layouts,
// operation codes and the table write controls.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int unsigned REQ_W   = 11;
  localparam int unsigned HEAD_W  = 10;
  localparam int unsigned FIRST_W = 11;
  localparam int unsigned DONE_W  = 11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // first_block answer when an allocate took nothing (-1)
  localparam logic [FIRST_W-1:0] NO_BLOCK = '1;
  // largest count that blocks_done can report
  localparam logic [DONE_W-1:0]  DONE_MAX = '1;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  block_request;
    logic [HEAD_W-1:0] head_block;
  } req_t;

  typedef struct packed {
    logic signed [FIRST_W-1:0] first_block;
    logic [DONE_W-1:0]         blocks_done;
  } rsp_t;

  typedef struct packed {
    logic busy_we;
    logic busy_wbit;
    logic link_we;
  } tbl_ctrl_t;

endpackage

/* rtl/fca_if.sv */
// ----------------------------------------------------------------------------
// fca_req_if / fca_rsp_if
// Valid/ready channels for requests into and results out of the allocator.
// ----------------------------------------------------------------------------
interface fca_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [fca_pkg::REQ_W-1:0]   block_request;
  logic [fca_pkg::HEAD_W-1:0]  head_block;

  modport source (output valid, operation, block_request, head_block, input ready);
  modport sink   (input valid, operation, block_request, head_block, output ready);
endinterface

interface fca_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [fca_pkg::FIRST_W-1:0] first_block;
  logic [fca_pkg::DONE_W-1:0]         blocks_done;

  modport source (output valid, first_block, blocks_done, input ready);
  modport sink   (input valid, first_block, blocks_done, output ready);
endinterface

/* rtl/fat_chain_allocator.sv */
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Block allocation table with chain allocate and chain free operations.
// ----------------------------------------------------------------------------
// After reset the block clears its table (every block free, every link at
// the end mark) and takes no request meanwhile. It then takes one request at
// a time: an allocate scans busy bits from entry 0 at one entry per cycle,
// and a free walks the chain one link per cycle. The single read port of
// each table memory sets that pace. A zero-block allocate, or a free whose
// head lies outside the table, goes straight to its result with no table
// access. The next request is taken once the result of the previous one has
// been loaded into the output register.
// A finished result sits in an output register, so a new request is taken
// while the previous result waits to be transferred.
module fat_chain_allocator #(
  parameter int unsigned ENTRIES = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  fca_req_if.sink    req_if_i,
  fca_rsp_if.source  rsp_if_o
);
  import fca_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = IW + 1;

  req_t      req;
  rsp_t      res;
  logic      res_valid;
  logic      res_ready;
  tbl_ctrl_t tbl_ctrl;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] busy_waddr;
  logic [IW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;
  logic          busy_rdata;
  logic [LW-1:0] link_rdata;

  logic rsp_valid_q;
  rsp_t rsp_q;

  assign req.operation     = req_if_i.operation;
  assign req.block_request = req_if_i.block_request;
  assign req.head_block    = req_if_i.head_block;

  fca_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if_i.valid),
    .req_i        (req),
    .req_ready_o  (req_if_i.ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .tbl_o        (tbl_ctrl),
    .rd_addr_o    (rd_addr),
    .busy_waddr_o (busy_waddr),
    .link_waddr_o (link_waddr),
    .link_wdata_o (link_wdata),
    .busy_rdata_i (busy_rdata),
    .link_rdata_i (link_rdata)
  );

  fca_table #(.ENTRIES(ENTRIES)) u_table (
    .clk_i        (clk_i),
    .ctrl_i       (tbl_ctrl),
    .rd_addr_i    (rd_addr),
    .busy_waddr_i (busy_waddr),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .busy_rdata_o (busy_rdata),
    .link_rdata_o (link_rdata)
  );

  // load a new result once the held one is transferred or the slot is empty
  assign res_ready = !rsp_valid_q || rsp_if_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (res_ready) begin
      rsp_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      rsp_q <= res;
    end
  end

  assign rsp_if_o.valid       = rsp_valid_q;
  assign rsp_if_o.first_block = rsp_q.first_block;
  assign rsp_if_o.blocks_done = rsp_q.blocks_done;

endmodule

/* rtl/fca_table.sv */
// ----------------------------------------------------------------------------
// fca_table
// Allocation table storage: one busy bit and one next link per block, each
// in a memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fca_table #(
  parameter int unsigned ENTRIES = 1024,
  localparam int unsigned IW = $clog2(ENTRIES),
  localparam int unsigned LW = IW + 1
) (
  input  logic               clk_i,
  input  fca_pkg::tbl_ctrl_t ctrl_i,
  input  logic [IW-1:0]      rd_addr_i,
  input  logic [IW-1:0]      busy_waddr_i,
  input  logic [IW-1:0]      link_waddr_i,
  input  logic [LW-1:0]      link_wdata_i,
  output logic               busy_rdata_o,
  output logic [LW-1:0]      link_rdata_o
);
  import fca_pkg::*;

  logic          busy_mem [ENTRIES];
  logic [LW-1:0] link_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.busy_we) begin
      busy_mem[busy_waddr_i] <= ctrl_i.busy_wbit;
    end
    busy_rdata_o <= busy_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rdata_o <= link_mem[rd_addr_i];
  end

endmodule

/* rtl/fca_seq.sv */
// ----------------------------------------------------------------------------
// fca_seq
// Sequencer of the allocator: clears the table after reset, scans busy bits
// for an allocate and walks next links for a free, one entry per cycle.
// ----------------------------------------------------------------------------
module fca_seq #(
  parameter int unsigned ENTRIES = 1024,
  localparam int unsigned IW = $clog2(ENTRIES),
  localparam int unsigned LW = IW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  fca_pkg::req_t       req_i,
  output logic                req_ready_o,
  output logic                res_valid_o,
  output fca_pkg::rsp_t       res_o,
  input  logic                res_ready_i,
  output fca_pkg::tbl_ctrl_t  tbl_o,
  output logic [IW-1:0]       rd_addr_o,
  output logic [IW-1:0]       busy_waddr_o,
  output logic [IW-1:0]       link_waddr_o,
  output logic [LW-1:0]       link_wdata_o,
  input  logic                busy_rdata_i,
  input  logic [LW-1:0]       link_rdata_i
);
  import fca_pkg::*;

  localparam int unsigned AW = IW + 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned MW = (CW > DONE_W) ? CW : DONE_W;
  localparam int unsigned XW = (IW > FIRST_W) ? IW : FIRST_W;

  localparam logic [AW-1:0] ADDR_END   = AW'(ENTRIES);
  localparam logic [IW-1:0] IDX_LAST   = IW'(ENTRIES - 1);
  localparam logic [LW-1:0] LINK_LIMIT = LW'(ENTRIES);
  localparam logic [LW-1:0] LINK_END   = '1;
  localparam logic [CW-1:0] CNT_LIMIT  = CW'(ENTRIES);
  localparam logic [31:0]   ENTRIES_32 = 32'(ENTRIES);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_TERM = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pend_idx_q, pend_idx_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [REQ_W-1:0]  want_q, want_d;
  logic              any_q, any_d;
  logic [IW-1:0]     first_q, first_d;
  logic [IW-1:0]     prev_q, prev_d;
  logic              op_q, op_d;
  logic [HEAD_W-1:0] head_q, head_d;

  logic [CW-1:0] cnt_inc;
  logic          head_in_range;
  logic [IW-1:0] head_idx;
  logic [IW-1:0] nxt_idx;
  logic [MW-1:0] cnt_ext;
  logic [XW-1:0] first_ext;

  assign cnt_inc       = cnt_q + 1'b1;
  assign head_in_range = 32'(req_i.head_block) < ENTRIES_32;
  assign head_idx      = IW'(req_i.head_block);
  assign nxt_idx       = link_rdata_i[IW-1:0];
  assign cnt_ext       = MW'(cnt_q);
  assign first_ext     = XW'(first_q);

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    if (op_q == OP_FREE) begin
      res_o.first_block = FIRST_W'(head_q);
    end else if (any_q) begin
      res_o.first_block = first_ext[FIRST_W-1:0];
    end else begin
      res_o.first_block = NO_BLOCK;
    end
    res_o.blocks_done = (cnt_ext > MW'(DONE_MAX)) ? DONE_MAX : cnt_ext[DONE_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    pend_d       = 1'b0;
    pend_idx_d   = addr_q[IW-1:0];
    cnt_d        = cnt_q;
    want_d       = want_q;
    any_d        = any_q;
    first_d      = first_q;
    prev_d       = prev_q;
    op_d         = op_q;
    head_d       = head_q;
    tbl_o        = '0;
    rd_addr_o    = addr_q[IW-1:0];
    busy_waddr_o = addr_q[IW-1:0];
    link_waddr_o = addr_q[IW-1:0];
    link_wdata_o = LINK_END;

    unique case (state_q)
      ST_INIT: begin
        // sweep the table to its reset contents
        tbl_o.busy_we = 1'b1;
        tbl_o.link_we = 1'b1;
        if (addr_q[IW-1:0] == IDX_LAST) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d   = req_i.operation;
          head_d = req_i.head_block;
          want_d = req_i.block_request;
          cnt_d  = '0;
          any_d  = 1'b0;
          addr_d = '0;
          if (req_i.operation == OP_ALLOC) begin
            state_d = (req_i.block_request == '0) ? ST_DONE : ST_SCAN;
          end else if (head_in_range) begin
            rd_addr_o       = head_idx;
            busy_waddr_o    = head_idx;
            tbl_o.busy_we   = 1'b1;
            tbl_o.busy_wbit = 1'b0;
            cnt_d           = CW'(1);
            state_d         = ST_WALK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // issue the next busy read while the previous one is evaluated
        if (addr_q < ADDR_END) begin
          pend_d     = 1'b1;
          pend_idx_d = addr_q[IW-1:0];
          addr_d     = addr_q + 1'b1;
        end
        if (pend_q) begin
          if (!busy_rdata_i) begin
            busy_waddr_o    = pend_idx_q;
            tbl_o.busy_we   = 1'b1;
            tbl_o.busy_wbit = 1'b1;
            if (any_q) begin
              link_waddr_o  = prev_q;
              link_wdata_o  = LW'(pend_idx_q);
              tbl_o.link_we = 1'b1;
            end else begin
              first_d = pend_idx_q;
              any_d   = 1'b1;
            end
            prev_d = pend_idx_q;
            cnt_d  = cnt_inc;
          end
          if ((!busy_rdata_i && (MW'(cnt_inc) == MW'(want_q))) ||
              (pend_idx_q == IDX_LAST)) begin
            pend_d  = 1'b0;
            state_d = any_d ? ST_TERM : ST_DONE;
          end
        end
      end
      ST_TERM: begin
        // close the new chain with the end mark
        link_waddr_o  = prev_q;
        link_wdata_o  = LINK_END;
        tbl_o.link_we = 1'b1;
        state_d       = ST_DONE;
      end
      ST_WALK: begin
        if ((link_rdata_i < LINK_LIMIT) && (cnt_q < CNT_LIMIT)) begin
          rd_addr_o       = nxt_idx;
          busy_waddr_o    = nxt_idx;
          tbl_o.busy_we   = 1'b1;
          tbl_o.busy_wbit = 1'b0;
          cnt_d           = cnt_inc;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      addr_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    cnt_q      <= cnt_d;
    want_q     <= want_d;
    any_q      <= any_d;
    first_q    <= first_d;
    prev_q     <= prev_d;
    op_q       <= op_d;
    head_q     <= head_d;
  end

  a_scan_below_want: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pend_q) |-> (MW'(cnt_q) < MW'(want_q)))
    else $error("scan evaluates an entry after the request was met");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q != '0 && cnt_q <= CNT_LIMIT))
    else $error("free walk count out of bounds");

  a_term_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM) |-> any_q)
    else $error("chain termination without a chain head");

  a_free_out_of_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && req_valid_i && req_i.operation == OP_FREE && !head_in_range)
    |=> (state_q == ST_DONE && cnt_q == '0))
    else $error("free of a head outside the table did not finish empty");

endmodule
